@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared field widths, item codes and the scan status bundle of the
// preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    // Item kinds carried on s_tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Fixed field widths on the ports
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_FIELD_W = 16;
    localparam int PRIO_W       = 8;
    localparam int CFG_W        = 5;

    // Packed stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    // Reset value of the slots-in-use register
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 5'd1;

    // Status of the scan engine toward the top level
    typedef struct packed {
        logic busy;      // scan in progress, no item may enter
        logic done;      // result is taken at this edge
        logic found;     // some slot was ready this tick
        logic all_done;  // every used slot has zero remaining after this tick
    } scan_status_t;

endpackage

@@ rtl/pps_slot_mem.sv @@
// ----------------------------------------------------------------------------
// pps_slot_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 40,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry into the registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/pps_scan.sv @@
// ----------------------------------------------------------------------------
// pps_scan
// Scan engine: walks the slot table one entry a cycle, keeps the best ready
// slot and, if one was found, writes back its decremented remaining time.
// ----------------------------------------------------------------------------
module pps_scan #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 16,
    parameter int IDX_W      = $clog2(SLOT_COUNT),
    parameter int CNT_W      = $clog2(SLOT_COUNT + 1),
    parameter int ENTRY_W    = 2 * TIME_BITS + pps_pkg::PRIO_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [CNT_W-1:0]      slot_count,
    input  logic [TIME_BITS-1:0]  cur_time,
    input  logic                  out_free,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    input  logic [ENTRY_W-1:0]    rd_data,
    output logic                  wb_en,
    output logic [IDX_W-1:0]      wb_addr,
    output logic [ENTRY_W-1:0]    wb_data,
    output logic [IDX_W-1:0]      best_idx,
    output logic [TIME_BITS-1:0]  left_after,
    output pps_pkg::scan_status_t status
);

    import pps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     tag_reg, tag_next;
    logic                 found_reg, found_next;
    logic [1:0]           nz_cnt_reg, nz_cnt_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] best_arr_reg, best_arr_next;
    logic [PRIO_W-1:0]    best_pri_reg, best_pri_next;
    logic [TIME_BITS-1:0] best_rem_reg, best_rem_next;

    logic [TIME_BITS-1:0] rd_arr;
    logic [PRIO_W-1:0]    rd_pri;
    logic [TIME_BITS-1:0] rd_rem;
    logic                 rem_nz;
    logic                 slot_ready;
    logic                 issue_ok;
    logic [TIME_BITS-1:0] rem_dec;
    logic                 scan_done;

    // Split the returned entry
    assign rd_arr     = rd_data[ENTRY_W-1 -: TIME_BITS];
    assign rd_pri     = rd_data[TIME_BITS +: PRIO_W];
    assign rd_rem     = rd_data[TIME_BITS-1:0];
    assign rem_nz     = (rd_rem != '0);
    assign slot_ready = (rd_arr <= cur_time) && rem_nz;
    assign issue_ok   = (issue_cnt_reg < slot_count);
    assign rem_dec    = best_rem_reg - TIME_BITS'(1);

    // Next-state and datapath
    always_comb begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        pend_next      = pend_reg;
        tag_next       = tag_reg;
        found_next     = found_reg;
        nz_cnt_next    = nz_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_arr_next  = best_arr_reg;
        best_pri_next  = best_pri_reg;
        best_rem_next  = best_rem_reg;
        rd_en          = 1'b0;
        wb_en          = 1'b0;
        scan_done      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    issue_cnt_next = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    nz_cnt_next    = '0;
                    best_idx_next  = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue the next read while evaluating the previous one
                rd_en     = issue_ok;
                pend_next = issue_ok;
                tag_next  = issue_cnt_reg[IDX_W-1:0];
                if (issue_ok) begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    if (rem_nz && nz_cnt_reg != 2'd2) begin
                        nz_cnt_next = nz_cnt_reg + 2'd1;
                    end
                    if (slot_ready && (!found_reg || rd_pri > best_pri_reg)) begin
                        found_next    = 1'b1;
                        best_idx_next = tag_reg;
                        best_arr_next = rd_arr;
                        best_pri_next = rd_pri;
                        best_rem_next = rd_rem;
                    end
                end
                if (!issue_ok && !pend_reg) begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                // Hand over the result and charge the winner
                if (out_free) begin
                    scan_done  = 1'b1;
                    wb_en      = found_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        issue_cnt_reg <= issue_cnt_next;
        tag_reg       <= tag_next;
        found_reg     <= found_next;
        nz_cnt_reg    <= nz_cnt_next;
        best_idx_reg  <= best_idx_next;
        best_arr_reg  <= best_arr_next;
        best_pri_reg  <= best_pri_next;
        best_rem_reg  <= best_rem_next;
    end

    assign rd_addr         = issue_cnt_reg[IDX_W-1:0];
    assign wb_addr         = best_idx_reg;
    assign wb_data         = {best_arr_reg, best_pri_reg, rem_dec};
    assign best_idx        = found_reg ? best_idx_reg : '0;
    assign left_after      = found_reg ? rem_dec : '0;
    assign status.busy     = (state_reg != S_IDLE);
    assign status.done     = scan_done;
    assign status.found    = found_reg;
    // Only the winner can drop to zero; everything else must already be zero
    assign status.all_done = (nz_cnt_reg == 2'd0)
                          || (nz_cnt_reg == 2'd1 && found_reg
                              && best_rem_reg == TIME_BITS'(1));

    // A write-back only charges a slot that had work left
    a_wb_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_en |-> best_rem_reg != '0)
        else $error("write-back of a slot with no remaining time");

    // Reads are issued only while scanning
    a_rd_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> state_reg == S_SCAN)
        else $error("table read outside the scan");

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// Load item: writes one slot entry; no result.
// Tick item: n = slots_in_use clamped to SLOT_COUNT; one table read a cycle over
//   the n used slots through the registered read port, then the write-back state
//   hands over the result and charges the winner, if any. Input is held off
//   meanwhile; the next item is taken once the scan is idle again, later while a result waits.
// Reset: time 0, slots_in_use 1, no result pending; table undefined until loaded.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Priority scheduler over a table of process slots, one tick per tick item.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: slots_in_use
    input  logic                                cfg_wr_en,
    input  logic [pps_pkg::CFG_W-1:0]           cfg_wr_data,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot_index[3:0], arrival_time[19:4], burst_length[35:20],
    // priority_level[43:36], zero pad[47:44]
    input  logic [pps_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,   // mode
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chosen_slot[3:0], left_after[19:4], ticks_elapsed[35:20], zero pad[39:36]
    output logic [pps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // idle_tick
    output logic                                m_tlast    // all_finished
);

    import pps_pkg::*;

    localparam int IDX_W    = $clog2(SLOT_COUNT);
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int ENTRY_W  = 2 * TIME_BITS + PRIO_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [CFG_W-1:0]       slots_in_use_reg;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;

    logic [CNT_W-1:0]       slot_count;
    logic                   in_fire;
    logic                   tick_start;
    logic                   load_wr;
    logic                   out_free;

    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [TIME_FIELD_W-1:0] in_arrival;
    logic [TIME_FIELD_W-1:0] in_burst;
    logic [PRIO_W-1:0]       in_prio;

    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [ENTRY_W-1:0]     mem_wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   wb_en;
    logic [IDX_W-1:0]       wb_addr;
    logic [ENTRY_W-1:0]     wb_data;
    logic [IDX_W-1:0]       best_idx;
    logic [TIME_BITS-1:0]   left_after;
    scan_status_t           status;

    // Unpack the input item
    assign in_slot    = s_tdata[3:0];
    assign in_arrival = s_tdata[19:4];
    assign in_burst   = s_tdata[35:20];
    assign in_prio    = s_tdata[43:36];

    // Clamp slots_in_use to the table size
    assign slot_count = (32'(slots_in_use_reg) > SLOT_COUNT) ? CNT_W'(SLOT_COUNT)
                                                             : CNT_W'(slots_in_use_reg);

    assign s_tready   = !status.busy;
    assign in_fire    = s_tvalid && s_tready;
    assign tick_start = in_fire && (s_tuser == MODE_TICK);
    assign load_wr    = in_fire && (s_tuser == MODE_LOAD)
                     && (32'(in_slot) < SLOT_COUNT);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Share the table write port between loads and write-back
    assign mem_wr_en   = load_wr || wb_en;
    assign mem_wr_addr = load_wr ? IDX_W'(in_slot) : wb_addr;
    assign mem_wr_data = load_wr ? {TIME_BITS'(in_arrival), in_prio, TIME_BITS'(in_burst)}
                                 : wb_data;

    // Advance time, saturating
    assign time_next = (time_reg != TIME_MAX) ? time_reg + TIME_BITS'(1) : time_reg;

    pps_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pps_scan #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (tick_start),
        .slot_count (slot_count),
        .cur_time   (time_reg),
        .out_free   (out_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wb_en      (wb_en),
        .wb_addr    (wb_addr),
        .wb_data    (wb_data),
        .best_idx   (best_idx),
        .left_after (left_after),
        .status     (status)
    );

    // Configuration register and current time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
            time_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                slots_in_use_reg <= cfg_wr_data;
            end
            if (status.done) begin
                time_reg <= time_next;
            end
        end
    end

    // Output register: capture a finished tick, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (status.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (status.done) begin
            m_tdata_reg <= {4'b0, 16'(time_next), 16'(left_after), 4'(best_idx)};
            m_tuser_reg <= !status.found;
            m_tlast_reg <= status.all_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // A finished scan always leaves a result in the output register
    a_done_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |=> m_tvalid)
        else $error("finished tick not presented");

    // An idle result reports slot zero with nothing left
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata[19:0] == 20'd0)
        else $error("idle tick carries a slot");

    // A tick item starts a scan
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_start |=> status.busy)
        else $error("tick accepted without a scan");

    // Time never runs backward outside reset
    a_time_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> time_reg >= $past(time_reg))
        else $error("current time decreased");

endmodule
